@@ rtl/mandelbrot_escape_iteration_assert.svh @@
// Assertion macros used by the controller of the Mandelbrot escape-time RTL.
`ifndef MANDELBROT_ESCAPE_ITERATION_ASSERT_SVH
`define MANDELBROT_ESCAPE_ITERATION_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define MEI_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mei assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define MEI_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mei assertion failed");
`else
`define MEI_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MEI_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/mei_pkg.sv @@
// Shared types and constants of the Mandelbrot escape-time block.
package mei_pkg;

   // Fixed-point format of c and z.
   localparam int FRAC_BITS = 26;
   localparam int Z_W       = 32;
   localparam int PROD_W    = 2 * Z_W;

   // Configuration register widths and reset values.
   localparam int LIMIT_W  = 16;
   localparam int RADIUS_W = 7;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(1000);
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(16);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATION_LIMIT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE_RADIUS_SQ = CSR_IDX_W'(1);

   // Inside-point counter.
   localparam int COUNT_W = 32;

   // Width of the escape compare: holds |z|^2 and radius * 2^(2*FRAC_BITS).
   localparam int CMP_W = (2 * FRAC_BITS + RADIUS_W > PROD_W) ?
                          (2 * FRAC_BITS + RADIUS_W) : PROD_W;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_HOLD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;   // load c, clear z and the step count
      logic mul;     // register the three products of z
      logic step;    // take z = z*z + c and count the step
      logic finish;  // load the result register and update the count
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stop;       // limit reached or z escaped
      logic limit_hit;  // step count equals the limit
   } status_type;

endpackage

@@ rtl/mei_ctrl.sv @@
// Controller state machine of the Mandelbrot escape-time block.
`include "mandelbrot_escape_iteration_assert.svh"

module mei_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mei_pkg::status_type status,
   output mei_pkg::cmd_type    cmd
);

   mei_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mei_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The result register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         mei_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = mei_pkg::ST_MUL;
            end
         end
         mei_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = mei_pkg::ST_EVAL;
         end
         mei_pkg::ST_EVAL: begin
            if (status.stop) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = mei_pkg::ST_IDLE;
               end else begin
                  state_in = mei_pkg::ST_HOLD;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = mei_pkg::ST_MUL;
            end
         end
         mei_pkg::ST_HOLD: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = mei_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mei_pkg::ST_IDLE;
         end
      endcase
   end

   // A finished result sets valid; taking it clears valid.
   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_ready = (state_ff == mei_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A result is never written over one that has not been taken.
   `MEI_ASSERT_SAME(a_finish_free, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready)
   // No step is taken once the iteration limit is reached.
   `MEI_ASSERT_SAME(a_step_below_limit, clock, reset, cmd.step, !status.limit_hit)
   // An accepted request always starts with a product cycle.
   `MEI_ASSERT_NEXT(a_start_mul, clock, reset, req_valid && req_ready,
                    state_ff == mei_pkg::ST_MUL)

endmodule

@@ rtl/mei_datapath.sv @@
// Datapath of the Mandelbrot escape-time block: z registers, products and counters.
module mei_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic signed [mei_pkg::Z_W-1:0]       req_c_real,
   input  logic signed [mei_pkg::Z_W-1:0]       req_c_imag,
   input  logic                                 csr_wr_en,
   input  logic [mei_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mei_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  mei_pkg::cmd_type                     cmd,
   output mei_pkg::status_type                  status,
   output logic [mei_pkg::LIMIT_W-1:0]          rsp_iterations,
   output logic                                 rsp_inside_res,
   output logic [mei_pkg::COUNT_W-1:0]          rsp_inside_total
);

   localparam int ZW = mei_pkg::Z_W;
   localparam int PW = mei_pkg::PROD_W;
   localparam int CW = mei_pkg::CMP_W;
   localparam logic signed [PW-1:0] Z_MAX = {{(PW-ZW+1){1'b0}}, {(ZW-1){1'b1}}};
   localparam logic signed [PW-1:0] Z_MIN = {{(PW-ZW+1){1'b1}}, {(ZW-1){1'b0}}};

   logic [mei_pkg::LIMIT_W-1:0]  limit_ff, limit_in;
   logic [mei_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [mei_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic signed [ZW-1:0] cr_ff, ci_ff;
   logic signed [ZW-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic [mei_pkg::LIMIT_W-1:0] n_ff, n_in;

   logic signed [PW-1:0] prr_ff, pii_ff, pri_ff;
   logic signed [PW-1:0] prr_in, pii_in, pri_in;

   logic [mei_pkg::LIMIT_W-1:0] iter_ff;
   logic                        inside_ff;
   logic [mei_pkg::COUNT_W-1:0] total_ff;

   logic [PW-1:0]        mag;
   logic [CW-1:0]        bound;
   logic                 escaped;
   logic                 limit_hit;
   logic signed [PW-1:0] re_sum, im_sum;

   // Clamp a wide signed value to the range of a z component.
   function automatic logic signed [ZW-1:0] sat_z(input logic signed [PW-1:0] v);
      logic signed [ZW-1:0] r;
      if (v > Z_MAX) begin
         r = Z_MAX[ZW-1:0];
      end else if (v < Z_MIN) begin
         r = Z_MIN[ZW-1:0];
      end else begin
         r = v[ZW-1:0];
      end
      return r;
   endfunction

   // Configuration registers; unknown indexes are ignored.
   always_comb begin
      limit_in  = limit_ff;
      radius_in = radius_ff;
      if (csr_wr_en && csr_index == mei_pkg::CSR_ITERATION_LIMIT) begin
         limit_in = csr_wdata[mei_pkg::LIMIT_W-1:0];
      end
      if (csr_wr_en && csr_index == mei_pkg::CSR_ESCAPE_RADIUS_SQ) begin
         radius_in = csr_wdata[mei_pkg::RADIUS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= mei_pkg::LIMIT_RESET;
         radius_ff <= mei_pkg::RADIUS_RESET;
         count_ff  <= '0;
      end else begin
         limit_ff  <= limit_in;
         radius_ff <= radius_in;
         count_ff  <= count_in;
      end
   end

   // Three signed 32x32 products of z, one multiplier each, registered.
   assign prr_in = zr_ff * zr_ff;
   assign pii_in = zi_ff * zi_ff;
   assign pri_in = zr_ff * zi_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prr_ff <= prr_in;
         pii_ff <= pii_in;
         pri_ff <= pri_in;
      end
   end

   // Escape test: exact |z|^2 against radius * 2^(2*FRAC_BITS).
   assign mag     = prr_ff + pii_ff;
   assign bound   = CW'(radius_ff) << (2 * mei_pkg::FRAC_BITS);
   assign escaped = CW'(mag) > bound;

   assign limit_hit = (n_ff == limit_ff);
   assign status    = '{stop: limit_hit || escaped, limit_hit: limit_hit};

   // Next z: scale back to FRAC_BITS fraction bits, add c, saturate.
   assign re_sum = ((prr_ff - pii_ff) >>> mei_pkg::FRAC_BITS) + PW'(cr_ff);
   assign im_sum = (pri_ff >>> (mei_pkg::FRAC_BITS - 1)) + PW'(ci_ff);

   always_comb begin
      zr_in = zr_ff;
      zi_in = zi_ff;
      n_in  = n_ff;
      if (cmd.start) begin
         zr_in = '0;
         zi_in = '0;
         n_in  = '0;
      end else if (cmd.step) begin
         zr_in = sat_z(re_sum);
         zi_in = sat_z(im_sum);
         n_in  = n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cr_ff <= req_c_real;
         ci_ff <= req_c_imag;
      end
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      n_ff  <= n_in;
   end

   // Saturating count of inside points, bumped when a result is finished.
   always_comb begin
      count_in = count_ff;
      if (cmd.finish && limit_hit && count_ff != '1) begin
         count_in = count_ff + 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         iter_ff   <= n_ff;
         inside_ff <= limit_hit;
         total_ff  <= count_in;
      end
   end

   assign rsp_iterations   = iter_ff;
   assign rsp_inside_res   = inside_ff;
   assign rsp_inside_total = total_ff;

endmodule

@@ rtl/mandelbrot_escape_iteration.sv @@
// Top level of the Mandelbrot escape-time block: controller and datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  c_real, c_imag (signed Q6.26)
//   rsp_      out        rsp_valid / rsp_ready  iterations, inside_res, inside_total
//   csr_      in         csr_wr_en              csr_index, csr_wdata
//
// Each step z = z*z + c passes ST_MUL, which registers the three 32x32 products,
// and ST_EVAL, which does the escape test and the z update. A point that stops
// is loaded into the result register from ST_EVAL, or from ST_HOLD while the last
// result is untaken; a new request is taken only back in ST_IDLE.
// Reset is synchronous and restores the limit (1000), squared radius (16) and count.
// A finished result waits in the result register while a new request is accepted; a
// second result waits in the datapath until the first has been taken.
module mandelbrot_escape_iteration (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [mei_pkg::Z_W-1:0]       req_c_real,
   input  logic signed [mei_pkg::Z_W-1:0]       req_c_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mei_pkg::LIMIT_W-1:0]          rsp_iterations,
   output logic                                 rsp_inside_res,
   output logic [mei_pkg::COUNT_W-1:0]          rsp_inside_total,
   input  logic                                 csr_wr_en,
   input  logic [mei_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mei_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   mei_pkg::cmd_type    cmd;
   mei_pkg::status_type status;

   // Sequencer for the iteration loop and the result handshake.
   mei_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic, configuration and result storage.
   mei_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_iterations   (rsp_iterations),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_inside_total (rsp_inside_total)
   );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Mandelbrot escape-time block.
`timescale 1ns / 100ps

module testbench;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 3;
   localparam int WATCHDOG_LIMIT  = 600000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PRESSURE_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_PHASES   = 10;
   localparam int PHASE_POINTS    = 48;

   // Q6.26 reference points.
   localparam int ONE = 1 << mei_pkg::FRAC_BITS;
   localparam logic signed [mei_pkg::Z_W-1:0] Z_MAX = {1'b0, {(mei_pkg::Z_W-1){1'b1}}};
   localparam logic signed [mei_pkg::Z_W-1:0] Z_MIN = {1'b1, {(mei_pkg::Z_W-1){1'b0}}};

   // One predicted response.
   typedef struct {
      logic [mei_pkg::LIMIT_W-1:0] iterations;
      logic                        inside_flag;
      logic [mei_pkg::COUNT_W-1:0] total;
   } escape_outcome_type;

   // Tracks the block's configuration and inside count, predicts each
   // accepted point and compares responses in order.
   class escape_ledger;
      logic [mei_pkg::LIMIT_W-1:0]  limit;
      logic [mei_pkg::RADIUS_W-1:0] radius;
      logic [mei_pkg::COUNT_W-1:0]  inside_count;
      escape_outcome_type           outcomes[$];
      int unsigned                  errors;

      function new();
         limit        = mei_pkg::LIMIT_RESET;
         radius       = mei_pkg::RADIUS_RESET;
         inside_count = '0;
         errors       = 0;
      endfunction

      // Unknown register indexes have no effect.
      function void write_register(logic [mei_pkg::CSR_IDX_W-1:0] idx,
                                   logic [mei_pkg::CSR_DATA_W-1:0] data);
         if (idx == mei_pkg::CSR_ITERATION_LIMIT) begin
            limit = data[mei_pkg::LIMIT_W-1:0];
         end else if (idx == mei_pkg::CSR_ESCAPE_RADIUS_SQ) begin
            radius = data[mei_pkg::RADIUS_W-1:0];
         end
      endfunction

      function int pending();
         return outcomes.size();
      endfunction

      // Clamp a wide component of z back into the signed 32-bit range.
      function longint saturate(longint v);
         if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
         if (v < -64'sh8000_0000) return -64'sh8000_0000;
         return v;
      endfunction

      // Exact |z|^2 compared with radius * 2^(2*FRAC_BITS).
      function bit is_escaped(longint zr, longint zi);
         logic [63:0] sq_r, sq_i, mag, bound;
         sq_r  = zr * zr;
         sq_i  = zi * zi;
         mag   = sq_r + sq_i;
         bound = 64'(radius) << (2 * mei_pkg::FRAC_BITS);
         return mag > bound;
      endfunction

      // Iterate z = z*z + c from zero and queue the response it should give.
      function void note_point(logic signed [mei_pkg::Z_W-1:0] c_re,
                               logic signed [mei_pkg::Z_W-1:0] c_im);
         longint             cr, ci, zr, zi, re, im;
         int unsigned        n;
         escape_outcome_type o;
         cr = c_re;
         ci = c_im;
         zr = 0;
         zi = 0;
         n  = 0;
         while (n < limit && !is_escaped(zr, zi)) begin
            re = ((zr * zr - zi * zi) >>> mei_pkg::FRAC_BITS) + cr;
            im = ((zr * zi) >>> (mei_pkg::FRAC_BITS - 1)) + ci;
            zr = saturate(re);
            zi = saturate(im);
            n++;
         end
         o.iterations  = n[mei_pkg::LIMIT_W-1:0];
         o.inside_flag = (n == limit);
         if (o.inside_flag && inside_count != '1) inside_count++;
         o.total = inside_count;
         outcomes.push_back(o);
      endfunction

      function void check_outcome(logic [mei_pkg::LIMIT_W-1:0] iterations, logic inside_flag,
                                  logic [mei_pkg::COUNT_W-1:0] total);
         escape_outcome_type o;
         if (outcomes.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: unexpected response: n=%0d in=%0b total=%0d",
                        $time, iterations, inside_flag, total);
            return;
         end
         o = outcomes.pop_front();
         if (iterations !== o.iterations || inside_flag !== o.inside_flag ||
             total !== o.total) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: expected n=%0d in=%0b total=%0d, got n=%0d in=%0b total=%0d",
                        $time, o.iterations, o.inside_flag, o.total,
                        iterations, inside_flag, total);
         end
      endfunction
   endclass

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_ready;
   logic signed [mei_pkg::Z_W-1:0]      req_c_real       = '0;
   logic signed [mei_pkg::Z_W-1:0]      req_c_imag       = '0;
   logic                                rsp_valid;
   logic                                rsp_ready        = 1'b0;
   logic [mei_pkg::LIMIT_W-1:0]         rsp_iterations;
   logic                                rsp_inside_res;
   logic [mei_pkg::COUNT_W-1:0]         rsp_inside_total;
   logic                                csr_wr_en        = 1'b0;
   logic [mei_pkg::CSR_IDX_W-1:0]       csr_index        = '0;
   logic [mei_pkg::CSR_DATA_W-1:0]      csr_wdata        = '0;

   escape_ledger ledger = new();
   int unsigned  idle_cycles = 0;
   bit           hold_pending = 1'b0;

   mandelbrot_escape_iteration uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_iterations   (rsp_iterations),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_inside_total (rsp_inside_total),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Idle stretch length: mostly none, sometimes short, rarely long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // One component of a corner point: zero, the range ends or one step off zero.
   function automatic logic signed [mei_pkg::Z_W-1:0] corner_component();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return Z_MAX;
         2: return Z_MIN;
         3: return 1;
         default: return -1;
      endcase
   endfunction

   // Offer one request after a random gap and wait for it to be taken.
   task automatic send_point(input logic signed [mei_pkg::Z_W-1:0] c_re,
                             input logic signed [mei_pkg::Z_W-1:0] c_im);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_c_real <= c_re;
      req_c_imag <= c_im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop offering and wait until every response has come back.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers, then a junk write to an unused index.
   task automatic apply_settings(input logic [mei_pkg::CSR_DATA_W-1:0] limit_word,
                                 input logic [mei_pkg::CSR_DATA_W-1:0] radius_word);
      csr_wr_en <= 1'b1;
      csr_index <= mei_pkg::CSR_ITERATION_LIMIT;
      csr_wdata <= limit_word;
      @(posedge clock);
      csr_index <= mei_pkg::CSR_ESCAPE_RADIUS_SQ;
      csr_wdata <= radius_word;
      @(posedge clock);
      csr_index <= mei_pkg::CSR_IDX_W'($urandom_range(int'(mei_pkg::CSR_ESCAPE_RADIUS_SQ) + 1,
                                                      (1 << mei_pkg::CSR_IDX_W) - 1));
      csr_wdata <= mei_pkg::CSR_DATA_W'($urandom);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random points: mostly near the set, the rest full-range, small or corner.
   task automatic send_random_points(input int count);
      logic signed [mei_pkg::Z_W-1:0] cr, ci;
      int unsigned                    sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 9);
         if (sel < 6) begin
            cr = -(9 * ONE / 4) + int'($urandom_range(0, 3 * ONE));
            ci = -(3 * ONE / 2) + int'($urandom_range(0, 3 * ONE));
         end else if (sel < 8) begin
            cr = $urandom;
            ci = $urandom;
         end else if (sel == 8) begin
            cr = $signed($urandom) >>> $urandom_range(2, 8);
            ci = $signed($urandom) >>> $urandom_range(2, 8);
         end else begin
            cr = corner_component();
            ci = corner_component();
         end
         send_point(cr, ci);
      end
   endtask

   // Response side: random stalls, with one long hold-off on request.
   initial begin
      int unsigned stall;
      @(posedge clock);
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end
         stall = pick_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12))
            @(posedge clock);
      end
   end

   // Monitor: track writes, check responses, note requests, watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) ledger.write_register(csr_index, csr_wdata);
         if (rsp_valid && rsp_ready)
            ledger.check_outcome(rsp_iterations, rsp_inside_res, rsp_inside_total);
         if (req_valid && req_ready) ledger.note_point(req_c_real, req_c_imag);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Main sequence.
   initial begin
      logic [mei_pkg::LIMIT_W-1:0]  phase_limit;
      logic [mei_pkg::RADIUS_W-1:0] phase_radius;
      int unsigned                  r;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: origin, c = -2 (orbit settles at z = 2), the radius boundary,
      // a slowly converging point and the range corners.
      send_point('0, '0);
      send_point(-2 * ONE, '0);
      send_point(4 * ONE, '0);
      send_point(ONE / 4, '0);
      send_point(Z_MAX, Z_MAX);
      send_point(Z_MIN, Z_MIN);
      send_point(Z_MIN, Z_MAX);
      settle();

      // Zero limit: no step at all, every point counts as inside.
      apply_settings('0, mei_pkg::CSR_DATA_W'(16));
      send_point('0, '0);
      send_point(Z_MAX, Z_MIN);
      settle();

      // Largest limit with zero radius: only z = 0 stays inside.
      apply_settings('1, '0);
      send_point('0, '0);
      send_point(1, '0);
      settle();

      // Widest radius, with junk above the radius bits: components overflow.
      apply_settings(mei_pkg::CSR_DATA_W'(20), {9'($urandom), {mei_pkg::RADIUS_W{1'b1}}});
      send_point(-8 * ONE, '0);
      send_point('0, 8 * ONE);
      send_point('0, -8 * ONE);
      send_point(-8 * ONE, -8 * ONE);
      settle();

      // Single step.
      apply_settings(mei_pkg::CSR_DATA_W'(1), mei_pkg::CSR_DATA_W'(64));
      send_point(Z_MAX, '0);
      send_point('0, '0);
      settle();

      // Random phases; the first one runs under a long response hold-off.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 9);
         if (phase == 0) phase_limit = mei_pkg::LIMIT_W'(4);
         else if (r == 0) phase_limit = '0;
         else if (r == 1) phase_limit = mei_pkg::LIMIT_W'(1);
         else if (r < 7) phase_limit = mei_pkg::LIMIT_W'($urandom_range(2, 40));
         else if (r < 9) phase_limit = mei_pkg::LIMIT_W'($urandom_range(41, 300));
         else phase_limit = mei_pkg::LIMIT_W'($urandom_range(301, 600));
         r = $urandom_range(0, 9);
         if (r == 0) phase_radius = '0;
         else if (r == 1) phase_radius = '1;
         else if (r == 2) phase_radius = mei_pkg::RADIUS_W'(64);
         else if (r == 3) phase_radius = mei_pkg::RADIUS_W'($urandom_range(1, 3));
         else phase_radius = mei_pkg::RADIUS_W'($urandom_range(4, 16));
         apply_settings(phase_limit, {9'($urandom), phase_radius});
         if (phase == 0) hold_pending = 1'b1;
         send_random_points(PHASE_POINTS);
         settle();
      end

      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/mei_pkg.sv
rtl/mei_ctrl.sv
rtl/mei_datapath.sv
rtl/mandelbrot_escape_iteration.sv
tb/sv/testbench.sv
